[design/clt_pkg.sv]
// shared types, character codes and helpers for the command line tokenizer
package clt_pkg;

    localparam int CNT_W = 13;
    localparam int CHAR_W = 16;
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 13'd4096;

    localparam logic IN_CHAR = 1'b0;
    localparam logic IN_EOL = 1'b1;

    localparam logic [1:0] RK_CHAR = 2'd0;
    localparam logic [1:0] RK_TOKEN_END = 2'd1;
    localparam logic [1:0] RK_LINE_OK = 2'd2;
    localparam logic [1:0] RK_UNMATCHED = 2'd3;

    localparam logic [CHAR_W-1:0] CH_NUL = 16'h0000;
    localparam logic [CHAR_W-1:0] CH_TAB = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_LF = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_ZERO = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_N = 16'h006E;
    localparam logic [CHAR_W-1:0] CH_T = 16'h0074;
    localparam logic [CHAR_W-1:0] CH_X = 16'h0078;

    localparam int MAX_RES = 3;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [CHAR_W-1:0] ch;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        logic [CNT_W-1:0] count;
        res_t [MAX_RES-1:0] res;
    } bundle_t;

    // returns {valid, digit value}
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 16'h0030 && c <= 16'h0039)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] escape_map(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = c;
        if (c == CH_N)
        begin
            v = CH_LF;
        end
        else if (c == CH_T)
        begin
            v = CH_TAB;
        end
        else if (c == CH_ZERO)
        begin
            v = CH_NUL;
        end
        return v;
    endfunction

endpackage

[design/clt_front.sv]
// front end: parser state and classification of each item into a result bundle
module clt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          kind,
    input  logic [clt_pkg::CHAR_W-1:0]    code,
    output logic                          push,
    output clt_pkg::bundle_t              bundle
);

    logic in_quotes_reg, in_quotes_next;
    logic escape_reg, escape_next;
    logic hex_reg, hex_next;
    logic [clt_pkg::CHAR_W-1:0] acc_reg, acc_next;
    logic has_chars_reg, has_chars_next;
    logic prev_quote_reg, prev_quote_next;
    logic [clt_pkg::CNT_W-1:0] tokens_reg, tokens_next;

    logic eol;
    logic [clt_pkg::CHAR_W-1:0] c;
    logic [4:0] hd;
    logic handle;
    logic [1:0] n;
    clt_pkg::bundle_t b;

    always_comb
    begin
        eol = (kind == clt_pkg::IN_EOL);
        c = eol ? clt_pkg::CH_NUL : code;
        hd = clt_pkg::hex_digit(c);
        in_quotes_next = in_quotes_reg;
        escape_next = escape_reg;
        hex_next = hex_reg;
        acc_next = acc_reg;
        has_chars_next = has_chars_reg;
        tokens_next = tokens_reg;
        handle = 1'b1;
        n = 2'd0;
        b = '0;

        if (escape_reg)
        begin
            escape_next = 1'b0;
            handle = 1'b0;
            if (c == clt_pkg::CH_X)
            begin
                hex_next = 1'b1;
                acc_next = '0;
            end
            else
            begin
                b.res[n] = '{kind: clt_pkg::RK_CHAR, ch: clt_pkg::escape_map(c)};
                n = n + 2'd1;
                has_chars_next = 1'b1;
            end
        end
        else if (hex_reg)
        begin
            if (hd[4])
            begin
                acc_next = {acc_reg[11:0], hd[3:0]};
                handle = 1'b0;
            end
            else
            begin
                b.res[n] = '{kind: clt_pkg::RK_CHAR, ch: acc_reg};
                n = n + 2'd1;
                has_chars_next = 1'b1;
                acc_next = '0;
                hex_next = 1'b0;
            end
        end

        if (handle)
        begin
            if (((c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB) && !in_quotes_reg)
                || c == clt_pkg::CH_NUL)
            begin
                if (has_chars_next || prev_quote_reg)
                begin
                    b.res[n] = '{kind: clt_pkg::RK_TOKEN_END, ch: '0};
                    n = n + 2'd1;
                    if (tokens_reg < clt_pkg::COUNT_LIMIT)
                    begin
                        tokens_next = tokens_reg + 13'd1;
                    end
                    has_chars_next = 1'b0;
                end
            end
            else if (c == clt_pkg::CH_QUOTE)
            begin
                in_quotes_next = !in_quotes_reg;
            end
            else if (c == clt_pkg::CH_BSLASH && in_quotes_reg)
            begin
                escape_next = 1'b1;
            end
            else
            begin
                b.res[n] = '{kind: clt_pkg::RK_CHAR, ch: c};
                n = n + 2'd1;
                has_chars_next = 1'b1;
            end
        end

        prev_quote_next = !eol && (c == clt_pkg::CH_QUOTE);

        if (eol)
        begin
            b.res[n] = '{kind: in_quotes_next ? clt_pkg::RK_UNMATCHED : clt_pkg::RK_LINE_OK,
                         ch: '0};
            n = n + 2'd1;
            b.count = tokens_next;
            in_quotes_next = 1'b0;
            escape_next = 1'b0;
            hex_next = 1'b0;
            acc_next = '0;
            has_chars_next = 1'b0;
            prev_quote_next = 1'b0;
            tokens_next = '0;
        end
        b.n = n;
    end

    assign bundle = b;
    assign push = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg <= 1'b0;
            escape_reg <= 1'b0;
            hex_reg <= 1'b0;
            acc_reg <= '0;
            has_chars_reg <= 1'b0;
            prev_quote_reg <= 1'b0;
            tokens_reg <= '0;
        end
        else if (accept)
        begin
            in_quotes_reg <= in_quotes_next;
            escape_reg <= escape_next;
            hex_reg <= hex_next;
            acc_reg <= acc_next;
            has_chars_reg <= has_chars_next;
            prev_quote_reg <= prev_quote_next;
            tokens_reg <= tokens_next;
        end
    end

endmodule

[design/clt_queue.sv]
// two-entry bundle queue between front and back ends
module clt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  clt_pkg::bundle_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output clt_pkg::bundle_t  head
);

    clt_pkg::bundle_t entry_reg [clt_pkg::QDEPTH];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full = (count_reg == 2'(clt_pkg::QDEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[design/clt_back.sv]
// back end: unrolls each bundle into result items through an output register
module clt_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_not_empty,
    input  clt_pkg::bundle_t        q_head,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);

    clt_pkg::bundle_t cur_reg;
    logic cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [1:0] out_kind_reg, out_kind_next;
    logic out_last_reg, out_last_next;

    logic load_out;
    logic cur_done;
    clt_pkg::res_t slot;
    logic is_line;

    always_comb
    begin
        load_out = !out_valid_reg || m_tready;
        slot = cur_reg.res[idx_reg];
        is_line = (slot.kind == clt_pkg::RK_LINE_OK) || (slot.kind == clt_pkg::RK_UNMATCHED);
        cur_done = cur_valid_reg && load_out && (idx_reg == cur_reg.n - 2'd1);
        q_pop = q_not_empty && (!cur_valid_reg || cur_done);

        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        if (load_out)
        begin
            out_valid_next = cur_valid_reg;
            out_kind_next = slot.kind;
            out_data_next = {3'b000, is_line ? cur_reg.count : 13'd0, slot.ch};
            out_last_next = (idx_reg == cur_reg.n - 2'd1);
        end

        cur_valid_next = cur_valid_reg;
        idx_next = idx_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            idx_next = 2'd0;
        end
        else if (cur_done)
        begin
            cur_valid_next = 1'b0;
            idx_next = 2'd0;
        end
        else if (cur_valid_reg && load_out)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_kind_reg;
    assign m_tlast = out_last_reg;

endmodule

[design/command_line_tokenizer.sv]
// top level of the command line tokenizer
//
//   channel   dir   tdata                          tuser             tlast
//   s_*       in    [15:0] code                    [0] kind          -
//   m_*       out   [15:0] char_out,               [1:0] result_kind last
//                   [28:16] token_count
//
// one item per cycle in while s_tready is high; one result item per cycle out while m_tready is high
// items with two or three results hold s_tready low once the two-entry queue fills
// a result item passes through the queue entry, the current bundle register and the output register
// either side may stall freely; the queue decouples the parser from the output register
// reset clears the parser state, the queue and the output register
module command_line_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // code
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // char_out, token_count, zero fill
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast
);

    logic accept;
    logic push;
    logic full;
    logic pop;
    logic not_empty;
    clt_pkg::bundle_t bundle;
    clt_pkg::bundle_t head;

    assign s_tready = !full;
    assign accept = s_tvalid && s_tready;

    clt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .kind   (s_tuser),
        .code   (s_tdata),
        .push   (push),
        .bundle (bundle)
    );

    clt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (bundle),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    clt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (not_empty),
        .q_head      (head),
        .q_pop       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

[tb/command_line_tokenizer_test.sv]
// testbench for the command line tokenizer: directed table, then random lines
module command_line_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [clt_pkg::CHAR_W-1:0] ch;
        logic [clt_pkg::CNT_W-1:0]  count;
        logic                       last;
    } token_result_t;

    typedef struct packed {
        logic                       kind;
        logic [clt_pkg::CHAR_W-1:0] code;
        logic                       typed;
        logic [1:0]                 want_kind;
        logic [clt_pkg::CHAR_W-1:0] want_ch;
        logic [clt_pkg::CNT_W-1:0]  want_count;
    } table_row_t;

    localparam int DIRECTED_ROWS = 29;
    localparam int RANDOM_ITEMS = 190;
    localparam int QUIET_TAIL = 40;

    localparam table_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{clt_pkg::IN_EOL,  16'hFFFF, 1'b1, clt_pkg::RK_LINE_OK, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, 16'h0061, 1'b1, clt_pkg::RK_CHAR, 16'h0061, 13'd0},
        '{clt_pkg::IN_CHAR, 16'hFFFF, 1'b1, clt_pkg::RK_CHAR, 16'hFFFF, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_SPACE, 1'b1, clt_pkg::RK_TOKEN_END, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_TAB, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_QUOTE, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_QUOTE, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_SPACE, 1'b1, clt_pkg::RK_TOKEN_END, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_QUOTE, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_SPACE, 1'b1, clt_pkg::RK_CHAR, clt_pkg::CH_SPACE, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_BSLASH, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_T, 1'b1, clt_pkg::RK_CHAR, clt_pkg::CH_TAB, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_BSLASH, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_X, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, 16'h0031, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, 16'h0041, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, 16'h0066, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, 16'h0039, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_ZERO, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, 16'h0067, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_NUL, 1'b1, clt_pkg::RK_TOKEN_END, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_BSLASH, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_EOL,  16'h1234, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_BSLASH, 1'b1, clt_pkg::RK_CHAR, clt_pkg::CH_BSLASH,
          13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_QUOTE, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_BSLASH, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, clt_pkg::CH_X, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_CHAR, 16'h0046, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0},
        '{clt_pkg::IN_EOL,  16'h0000, 1'b0, clt_pkg::RK_CHAR, 16'h0000, 13'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    token_result_t pending_results[$];

    logic                        quoted;
    logic                        escaping;
    logic                        hex_mode;
    logic [clt_pkg::CHAR_W-1:0]  hex_value;
    logic                        token_open;
    logic                        after_quote;
    logic [clt_pkg::CNT_W-1:0]   token_tally;

    int send_gap_pct = 30;
    int recv_stall_pct = 30;
    int accept_mark;
    int items_sent;
    int lines_seen;
    int most_tokens;
    int results_checked;
    int failures;

    command_line_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_parser();
        quoted = 1'b0;
        escaping = 1'b0;
        hex_mode = 1'b0;
        hex_value = '0;
        token_open = 1'b0;
        after_quote = 1'b0;
        token_tally = '0;
    endfunction

    function automatic void add_result(input logic [1:0] kind,
                                       input logic [clt_pkg::CHAR_W-1:0] ch,
                                       input logic [clt_pkg::CNT_W-1:0] count);
        token_result_t r;
        r = '{kind, ch, count, 1'b0};
        pending_results.push_back(r);
    endfunction

    function automatic void tokenize_step(input logic kind,
                                          input logic [clt_pkg::CHAR_W-1:0] code);
        logic [clt_pkg::CHAR_W-1:0] c;
        logic [clt_pkg::CHAR_W-1:0] digit;
        bit                         is_digit;
        bit                         handle;
        int                         first;
        token_result_t              tail;
        c = (kind == clt_pkg::IN_EOL) ? clt_pkg::CH_NUL : code;
        handle = 1'b1;
        first = pending_results.size();
        if (escaping)
        begin
            escaping = 1'b0;
            handle = 1'b0;
            if (c == clt_pkg::CH_X)
            begin
                hex_mode = 1'b1;
                hex_value = '0;
            end
            else
            begin
                case (c)
                    clt_pkg::CH_N:    add_result(clt_pkg::RK_CHAR, clt_pkg::CH_LF, '0);
                    clt_pkg::CH_T:    add_result(clt_pkg::RK_CHAR, clt_pkg::CH_TAB, '0);
                    clt_pkg::CH_ZERO: add_result(clt_pkg::RK_CHAR, clt_pkg::CH_NUL, '0);
                    default:          add_result(clt_pkg::RK_CHAR, c, '0);
                endcase
                token_open = 1'b1;
            end
        end
        else if (hex_mode)
        begin
            is_digit = 1'b1;
            digit = '0;
            if (c >= 16'h0030 && c <= 16'h0039)
                digit = c - 16'h0030;
            else if (c >= 16'h0061 && c <= 16'h0066)
                digit = c - 16'h0057;
            else if (c >= 16'h0041 && c <= 16'h0046)
                digit = c - 16'h0037;
            else
                is_digit = 1'b0;
            if (is_digit)
            begin
                hex_value = {hex_value[11:0], digit[3:0]};
                handle = 1'b0;
            end
            else
            begin
                add_result(clt_pkg::RK_CHAR, hex_value, '0);
                token_open = 1'b1;
                hex_value = '0;
                hex_mode = 1'b0;
            end
        end
        if (handle)
        begin
            if (((c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB) && !quoted)
                || c == clt_pkg::CH_NUL)
            begin
                if (token_open || after_quote)
                begin
                    add_result(clt_pkg::RK_TOKEN_END, '0, '0);
                    if (token_tally < clt_pkg::COUNT_LIMIT)
                        token_tally = token_tally + 13'd1;
                    token_open = 1'b0;
                end
            end
            else if (c == clt_pkg::CH_QUOTE)
                quoted = !quoted;
            else if (c == clt_pkg::CH_BSLASH && quoted)
                escaping = 1'b1;
            else
            begin
                add_result(clt_pkg::RK_CHAR, c, '0);
                token_open = 1'b1;
            end
        end
        after_quote = (kind == clt_pkg::IN_CHAR && c == clt_pkg::CH_QUOTE);
        if (kind == clt_pkg::IN_EOL)
        begin
            add_result(quoted ? clt_pkg::RK_UNMATCHED : clt_pkg::RK_LINE_OK, '0, token_tally);
            lines_seen++;
            if (int'(token_tally) > most_tokens)
                most_tokens = int'(token_tally);
            clear_parser();
        end
        if (pending_results.size() > first)
        begin
            tail = pending_results.pop_back();
            tail.last = 1'b1;
            pending_results.push_back(tail);
        end
    endfunction

    task automatic send_item(input logic kind, input logic [clt_pkg::CHAR_W-1:0] code);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= code;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        accept_mark = pending_results.size();
        tokenize_step(kind, code);
        items_sent++;
    endtask

    task automatic random_line();
        int                         chunks;
        int                         j;
        logic [clt_pkg::CHAR_W-1:0] pick;
        chunks = $urandom_range(1, 6);
        for (j = 0; j < chunks; j++)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    repeat ($urandom_range(1, 4))
                        send_item(clt_pkg::IN_CHAR, 16'h0061 + 16'($urandom_range(0, 25)));
                end
                1:
                begin
                    case ($urandom_range(0, 2))
                        0:       pick = clt_pkg::CH_SPACE;
                        1:       pick = clt_pkg::CH_TAB;
                        default: pick = clt_pkg::CH_NUL;
                    endcase
                    send_item(clt_pkg::IN_CHAR, pick);
                end
                2, 3:
                begin
                    send_item(clt_pkg::IN_CHAR, clt_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 4))
                    begin
                        case ($urandom_range(0, 5))
                            0: send_item(clt_pkg::IN_CHAR,
                                         16'h0041 + 16'($urandom_range(0, 25)));
                            1: send_item(clt_pkg::IN_CHAR, $urandom_range(0, 1) ?
                                         clt_pkg::CH_SPACE : clt_pkg::CH_TAB);
                            2:
                            begin
                                case ($urandom_range(0, 5))
                                    0:       pick = clt_pkg::CH_N;
                                    1:       pick = clt_pkg::CH_T;
                                    2:       pick = clt_pkg::CH_ZERO;
                                    3:       pick = clt_pkg::CH_QUOTE;
                                    4:       pick = clt_pkg::CH_BSLASH;
                                    default: pick = 16'($urandom);
                                endcase
                                send_item(clt_pkg::IN_CHAR, clt_pkg::CH_BSLASH);
                                send_item(clt_pkg::IN_CHAR, pick);
                            end
                            3:
                            begin
                                send_item(clt_pkg::IN_CHAR, clt_pkg::CH_BSLASH);
                                send_item(clt_pkg::IN_CHAR, clt_pkg::CH_X);
                                repeat ($urandom_range(1, 5))
                                begin
                                    pick = 16'($urandom_range(0, 21));
                                    if (pick < 10)
                                        pick = 16'h0030 + pick;
                                    else if (pick < 16)
                                        pick = 16'h0057 + pick;
                                    else
                                        pick = 16'h0031 + pick;
                                    send_item(clt_pkg::IN_CHAR, pick);
                                end
                            end
                            4: send_item(clt_pkg::IN_CHAR, clt_pkg::CH_NUL);
                            default: send_item(clt_pkg::IN_CHAR, 16'($urandom));
                        endcase
                    end
                    if ($urandom_range(0, 9) != 0)
                        send_item(clt_pkg::IN_CHAR, clt_pkg::CH_QUOTE);
                end
                default:
                begin
                    send_item(clt_pkg::IN_CHAR, $urandom_range(0, 1) ? 16'($urandom)
                                                : 16'($urandom_range(0, 16'h007F)));
                end
            endcase
        end
        // sometimes leave an escape open at line end
        if ($urandom_range(0, 7) == 0)
        begin
            if (!quoted)
                send_item(clt_pkg::IN_CHAR, clt_pkg::CH_QUOTE);
            send_item(clt_pkg::IN_CHAR, clt_pkg::CH_BSLASH);
        end
        send_item(clt_pkg::IN_EOL, 16'($urandom));
    endtask

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        token_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected item, expected none, actual kind %0d char %h count %0d",
                         $time, m_tuser, m_tdata[15:0], m_tdata[28:16]);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(m_tuser));
                check_field("char_out", 32'(want.ch), 32'(m_tdata[15:0]));
                check_field("token_count", 32'(want.count), 32'(m_tdata[28:16]));
                check_field("last", 32'(want.last), 32'(m_tlast));
                check_field("zero fill", '0, 32'(m_tdata[31:29]));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct)
        begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        m_tready <= 1'b1;
    end

    initial
    begin
        #10ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int                k;
        int                random_start;
        token_result_t     want;
        token_result_t     dropped;
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            send_item(DIRECTED[k].kind, DIRECTED[k].code);
            if (DIRECTED[k].typed)
            begin
                while (pending_results.size() > accept_mark)
                    dropped = pending_results.pop_back();
                want = '{DIRECTED[k].want_kind, DIRECTED[k].want_ch, DIRECTED[k].want_count, 1'b1};
                pending_results.push_back(want);
            end
        end

        // hold the sender until the block has drained
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (items_sent - random_start >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            else
            begin
                send_gap_pct = 25 * $urandom_range(0, 2);
                recv_stall_pct = 25 * $urandom_range(0, 2);
            end
            random_line();
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (10) @(posedge clk);

        $display("covered %0d items over %0d lines, %0d result items checked",
                 items_sent, lines_seen, results_checked);
        $display("longest line reported %0d tokens, %0d mismatches", most_tokens, failures);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
design/clt_pkg.sv
design/clt_front.sv
design/clt_queue.sv
design/clt_back.sv
design/command_line_tokenizer.sv
tb/command_line_tokenizer_test.sv
